// ===== design/wtpi_pkg.sv =====
// Shared constants and types of the windowed time-per-item estimator.
package wtpi_pkg;

  localparam int EVENT_DEPTH     = 64;
  localparam int TIME_BITS       = 48;
  localparam int ELAPSED_BITS    = 32;
  localparam int COUNT_BITS      = 16;
  localparam int WINDOW_BITS     = 32;
  localparam int SPEED_BITS      = 56;
  localparam int FRAC_BITS       = 8;
  localparam int MIN_KEPT_EVENTS = 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam int SLOT_BITS   = $clog2(EVENT_DEPTH);
  localparam int TOTAL_BITS  = $clog2(EVENT_DEPTH + 1);
  localparam int WSUM_BITS   = COUNT_BITS + $clog2(EVENT_DEPTH);
  localparam int DIV_BITS    = TIME_BITS + FRAC_BITS;
  localparam int ENTRY_BITS  = TIME_BITS + COUNT_BITS;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(10000000);

  // one queued report, classified by the front end
  typedef struct packed {
    logic                    is_report;
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [COUNT_BITS-1:0]   count;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_BITS-1:0]  dividend;
    logic [WSUM_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/wtpi_rpt_if.sv =====
// Report channel: job duration and item count.
interface wtpi_rpt_if;
  import wtpi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ELAPSED_BITS-1:0] elapsed_ticks;
  logic [COUNT_BITS-1:0]   item_count;
  modport source (output valid, output elapsed_ticks, output item_count, input ready);
  modport sink   (input valid, input elapsed_ticks, input item_count, output ready);
endinterface

// ===== design/wtpi_est_if.sv =====
// Estimate channel: ticks per item and its valid flag.
interface wtpi_est_if;
  import wtpi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SPEED_BITS-1:0] ticks_per_item;
  logic                  estimate_valid;
  modport source (output valid, output ticks_per_item, output estimate_valid, input ready);
  modport sink   (input valid, input ticks_per_item, input estimate_valid, output ready);
endinterface

// ===== design/wtpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wtpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/wtpi_front.sv =====
// Front end: takes report transfers, tags zero-count reports, queues them.
module wtpi_front (
  input  logic              clk,
  input  logic              rst,
  wtpi_rpt_if.sink          rpt,
  input  logic              pop,
  output wtpi_pkg::q_head_t head
);
  import wtpi_pkg::*;

  item_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] fill;
  logic                 push;

  assign rpt.ready = (fill != QCNT_BITS'(QUEUE_DEPTH));
  assign push      = rpt.valid && rpt.ready;

  assign head.valid = (fill != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{is_report: (rpt.item_count != '0),
                           elapsed:   rpt.elapsed_ticks,
                           count:     rpt.item_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/wtpi_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module wtpi_div (
  input  logic               clk,
  input  logic               rst,
  input  wtpi_pkg::div_req_t req,
  output wtpi_pkg::div_rsp_t rsp
);
  import wtpi_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);

  logic                 run;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [DIV_BITS-1:0]  quo;
  logic [WSUM_BITS-1:0] rem;
  logic [WSUM_BITS-1:0] dvs;
  logic [WSUM_BITS:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs});

  assign rsp = '{done: done, quotient: quo};

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (run) begin
      quo <= {quo[DIV_BITS-2:0], fits};
      rem <= fits ? WSUM_BITS'(trial - {1'b0, dvs}) : trial[WSUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CNT_BITS'(DIV_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/wtpi_back.sv =====
// Back end: event ring upkeep, window expiry walk, division and result register.
module wtpi_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wtpi_pkg::WINDOW_BITS-1:0] cfg_wdata,
  input  wtpi_pkg::q_head_t                head,
  output logic                             pop,
  wtpi_est_if.source                       est
);
  import wtpi_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_TRIM = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] s);
    return (s == SLOT_BITS'(EVENT_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [2:0]             state;
  logic [WINDOW_BITS-1:0] window_ticks;
  logic [SLOT_BITS-1:0]   oldest_slot;
  logic [SLOT_BITS-1:0]   newest_slot;
  logic [TOTAL_BITS-1:0]  event_total;
  logic [WSUM_BITS-1:0]   weight_sum;
  logic [TIME_BITS-1:0]   newest_time;
  logic [TIME_BITS-1:0]   oldest_time;
  logic [COUNT_BITS-1:0]  oldest_wt;
  logic [SPEED_BITS-1:0]  held_speed;
  logic                   speed_known;

  logic                   take;
  logic                   ring_full;
  logic [TIME_BITS-1:0]   t_new;
  logic [TIME_BITS-1:0]   span;
  logic                   expire;
  logic                   out_free;
  logic                   ram_wr_en;
  logic                   ram_rd_en;
  logic [ENTRY_BITS-1:0]  ram_rd_data;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [SPEED_BITS-1:0]  quo_sat;

  assign take      = (state == ST_IDLE) && head.valid;
  assign pop       = take;
  assign ring_full = (event_total >= TOTAL_BITS'(EVENT_DEPTH));
  assign t_new     = newest_time + TIME_BITS'(head.item.elapsed);
  assign span      = newest_time - oldest_time;
  assign expire    = (span > TIME_BITS'(window_ticks)) &&
                     (event_total > TOTAL_BITS'(MIN_KEPT_EVENTS));
  assign out_free  = !est.valid || est.ready;

  assign ram_wr_en = take && head.item.is_report;
  // a drop always refills the oldest-entry cache from the next slot
  assign ram_rd_en = (ram_wr_en && ring_full) || ((state == ST_TRIM) && expire);

  wtpi_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (EVENT_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (next_slot(newest_slot)),
    .wr_data ({t_new, head.item.count}),
    .rd_en   (ram_rd_en),
    .rd_addr (next_slot(oldest_slot)),
    .rd_data (ram_rd_data)
  );

  assign div_req.start    = (state == ST_TRIM) && !expire && (weight_sum != '0);
  assign div_req.dividend = {span, FRAC_BITS'(0)};
  assign div_req.divisor  = weight_sum;

  wtpi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign quo_sat = ((div_rsp.quotient >> SPEED_BITS) != '0) ? {SPEED_BITS{1'b1}}
                                                            : SPEED_BITS'(div_rsp.quotient);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_ticks <= WINDOW_RESET;
      oldest_slot  <= '0;
      newest_slot  <= '0;
      event_total  <= TOTAL_BITS'(1);
      weight_sum   <= '0;
      newest_time  <= '0;
      oldest_time  <= '0;
      oldest_wt    <= '0;
      held_speed   <= '0;
      speed_known  <= 1'b0;
      est.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_ticks <= cfg_wdata;
      end
      if (est.valid && est.ready) begin
        est.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (!head.item.is_report) begin
              state <= ST_OUT;
            end else begin
              newest_slot <= next_slot(newest_slot);
              newest_time <= t_new;
              if (ring_full) begin
                oldest_slot <= next_slot(oldest_slot);
                weight_sum  <= weight_sum - WSUM_BITS'(oldest_wt)
                               + WSUM_BITS'(head.item.count);
                state       <= ST_LOAD;
              end else begin
                event_total <= event_total + 1'b1;
                weight_sum  <= weight_sum + WSUM_BITS'(head.item.count);
                state       <= ST_TRIM;
              end
            end
          end
        end
        ST_LOAD: begin
          oldest_time <= ram_rd_data[ENTRY_BITS-1:COUNT_BITS];
          oldest_wt   <= ram_rd_data[COUNT_BITS-1:0];
          state       <= ST_TRIM;
        end
        ST_TRIM: begin
          if (expire) begin
            oldest_slot <= next_slot(oldest_slot);
            event_total <= event_total - 1'b1;
            weight_sum  <= weight_sum - WSUM_BITS'(oldest_wt);
            state       <= ST_LOAD;
          end else if (weight_sum != '0) begin
            state <= ST_DIV;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            held_speed  <= quo_sat;
            speed_known <= 1'b1;
            state       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            est.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      est.ticks_per_item <= held_speed;
      est.estimate_valid <= speed_known;
    end
  end

endmodule

// ===== design/windowed_time_per_item_estimator_core.sv =====
// Top level of the windowed time-per-item estimator.
//
// Usage:
//   rpt  : report transfers (elapsed_ticks, item_count), one per finished job.
//   est  : one estimate transfer per report (ticks_per_item with 8 fraction
//          bits, estimate_valid), in report order.
//   cfg  : cfg_we/cfg_wdata write window_ticks; write only while idle.
// Processing steps:
//   zero-count report : queue head, output step, result register.
//   counted report    : ring update (a full ring drops its oldest event
//                       and reads the next one), then the expiry walk,
//                       which reads one ring entry per dropped event
//                       through the registered RAM port, then the 56-step
//                       serial divider and the result register.
//   A two-entry queue takes new reports while the back end works.
// Reset: ring holds one event at time zero, window_ticks = 10000000,
//   the held estimate is zero and not yet valid; no clearing pass is needed.
// Receiver stall: the result register holds; the back end waits in its
//   output step and the queue keeps accepting until it fills.
module windowed_time_per_item_estimator_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wtpi_pkg::WINDOW_BITS-1:0] cfg_wdata,
  wtpi_rpt_if.sink                         rpt,
  wtpi_est_if.source                       est
);
  import wtpi_pkg::*;

  // queue head seen by the back end, and its pop strobe
  q_head_t q_head;
  logic    q_pop;

  // front: accepts and classifies report transfers
  wtpi_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rpt  (rpt),
    .pop  (q_pop),
    .head (q_head)
  );

  // back: ring update, expiry walk, division, result register
  wtpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .pop       (q_pop),
    .est       (est)
  );

  // the back end never pops an empty queue
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // no estimate value is shown before the first counted report
  a_zero_until_known: assert property (@(posedge clk) disable iff (rst)
    (est.valid && !est.estimate_valid) |-> (est.ticks_per_item == '0))
    else $error("nonzero estimate while not valid");

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !est.valid)
    else $error("result valid right after reset");

endmodule
